// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cts_pkg.sv -----
// Types and constants of the cooperative task scheduler.
package cts_pkg;

  localparam int NumSlotsDefault = 8;
  localparam int MaxResults      = 8;
  localparam int ResCntW         = $clog2(MaxResults + 1);

  localparam int KindW     = 2;
  localparam int TaskIdW   = 8;
  localparam int TimeW     = 16;
  localparam int ReqSlotW  = 3;
  localparam int SlotOutW  = 4;
  localparam int StatusW   = 2;
  localparam int PendingW  = 8;

  typedef enum logic [KindW-1:0] {
    KIND_TICK     = 2'd0,
    KIND_ADD      = 2'd1,
    KIND_DELETE   = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_t;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_NODEL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EXEC   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  // One slot of the task table as stored in RAM.
  typedef struct packed {
    logic [TaskIdW-1:0]  tid;
    logic [TimeW-1:0]    delay;
    logic [TimeW-1:0]    period;
    logic [PendingW-1:0] pending;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // One result as held in the output register.
  typedef struct packed {
    logic [SlotOutW-1:0] slot_out;
    status_t             status;
    logic                ran;
    logic [TaskIdW-1:0]  run_task_id;
    status_t             sticky_error;
    logic                last;
  } res_t;

endpackage

// ----- rtl/cts_req_if.sv -----
// Request channel of the scheduler: operation and its operands.
interface cts_req_if
  import cts_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [TaskIdW-1:0]  task_id;
  logic [TimeW-1:0]    start_delay;
  logic [TimeW-1:0]    run_period;
  logic [ReqSlotW-1:0] slot;

  modport source (output valid, kind, task_id, start_delay, run_period, slot,
                  input ready);
  modport sink (input valid, kind, task_id, start_delay, run_period, slot,
                output ready);
endinterface

// ----- rtl/cts_res_if.sv -----
// Result channel of the scheduler.
interface cts_res_if
  import cts_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [SlotOutW-1:0] slot_out;
  logic [StatusW-1:0]  status;
  logic                ran;
  logic [TaskIdW-1:0]  run_task_id;
  logic [StatusW-1:0]  sticky_error;
  logic                last;

  modport source (output valid, slot_out, status, ran, run_task_id, sticky_error, last,
                  input ready);
  modport sink (input valid, slot_out, status, ran, run_task_id, sticky_error, last,
                output ready);
endinterface

// ----- rtl/cts_ram.sv -----
// Generic simple dual-port RAM with registered read.
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cooperative_task_scheduler_core.sv -----
// Cooperative task scheduler core: a table of NUM_SLOTS timed tasks kept in
// one RAM (id, delay, period, pending runs) with occupancy bits in flops.
// Add and delete complete in the cycle they are accepted and give one result.
// Tick and dispatch walk the table slot by slot: a free slot is skipped, an
// occupied slot is read from RAM, then modified and written back, and a
// finish state ends the walk and loads the last result. Dispatch
// returns one result per slot with pending runs, in slot order, at most
// eight per request, and may stall on the result channel. A new request is
// taken only when the walk is done and the result register can load.
`include "assert_macros.svh"

module cooperative_task_scheduler_core
  import cts_pkg::*;
#(
  parameter int NUM_SLOTS = NumSlotsDefault
) (
  input logic       clk,
  input logic       rst,
  cts_req_if.sink   req,
  cts_res_if.source res
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  state_t               state;
  logic                 op_dispatch;
  logic [CW-1:0]        idx;
  logic [ResCntW-1:0]   n_res;
  logic [NUM_SLOTS-1:0] slot_valid;
  status_t              err_latch;

  logic                 hold_valid;
  logic [SlotOutW-1:0]  hold_slot;
  logic [TaskIdW-1:0]   hold_task;

  logic                 out_valid;
  res_t                 out_pl;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  entry_t               ram_wdata;
  logic                 ram_re;
  logic [EntryW-1:0]    ram_rdata;
  entry_t               rd_entry;

  logic                 out_free;
  logic                 req_fire;
  logic [IW-1:0]        cur;
  logic                 at_end;
  logic                 free_found;
  logic [IW-1:0]        free_idx;
  logic                 del_in_range;
  logic [IW-1:0]        del_idx;
  logic                 disp_go;
  entry_t               tick_entry;
  entry_t               disp_entry;

  function automatic res_t make_res(logic [SlotOutW-1:0] s, status_t st, logic r,
                                    logic [TaskIdW-1:0] t, status_t sticky, logic l);
    res_t o;
    o.slot_out     = s;
    o.status       = st;
    o.ran          = r;
    o.run_task_id  = t;
    o.sticky_error = sticky;
    o.last         = l;
    return o;
  endfunction

  cts_ram #(
    .WIDTH (EntryW),
    .DEPTH (NUM_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign out_free = !out_valid || res.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign req_fire = req.valid && req.ready;
  assign cur = idx[IW-1:0];
  assign at_end = (idx == CW'(NUM_SLOTS)) ||
                  (op_dispatch && (n_res == ResCntW'(MaxResults)));
  assign del_in_range = {29'd0, req.slot} < 32'(NUM_SLOTS);
  assign del_idx = IW'(req.slot);
  // a found task may move on only once the previous one can leave the hold stage
  assign disp_go = (rd_entry.pending != '0) && (!hold_valid || out_free);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  always_comb begin
    tick_entry = rd_entry;
    if (rd_entry.delay == '0) begin
      if (rd_entry.pending != {PendingW{1'b1}}) begin
        tick_entry.pending = rd_entry.pending + 1'b1;
      end
      if (rd_entry.period != '0) begin
        tick_entry.delay = rd_entry.period;
      end
    end else begin
      tick_entry.delay = rd_entry.delay - 1'b1;
    end
    disp_entry = rd_entry;
    disp_entry.pending = rd_entry.pending - 1'b1;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = tick_entry;
    ram_re    = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire && (kind_t'(req.kind) == KIND_ADD) && free_found) begin
          ram_we            = 1'b1;
          ram_waddr         = free_idx;
          ram_wdata.tid     = req.task_id;
          ram_wdata.delay   = req.start_delay;
          ram_wdata.period  = req.run_period;
          ram_wdata.pending = '0;
        end
      end
      S_READ: begin
        ram_re = !at_end && slot_valid[cur];
      end
      S_EXEC: begin
        if (!op_dispatch) begin
          ram_we = 1'b1;
        end else if (disp_go && (rd_entry.period != '0)) begin
          ram_we    = 1'b1;
          ram_wdata = disp_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      op_dispatch <= 1'b0;
      idx         <= '0;
      n_res       <= '0;
      slot_valid  <= '0;
      err_latch   <= STATUS_OK;
      hold_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (kind_t'(req.kind))
              KIND_ADD: begin
                out_valid <= 1'b1;
                if (free_found) begin
                  slot_valid[free_idx] <= 1'b1;
                  out_pl <= make_res(SlotOutW'(free_idx), STATUS_OK, 1'b0, '0,
                                     err_latch, 1'b1);
                end else begin
                  err_latch <= STATUS_FULL;
                  out_pl <= make_res(SlotOutW'(NUM_SLOTS), STATUS_FULL, 1'b0, '0,
                                     STATUS_FULL, 1'b1);
                end
              end
              KIND_DELETE: begin
                out_valid <= 1'b1;
                if (del_in_range && slot_valid[del_idx]) begin
                  slot_valid[del_idx] <= 1'b0;
                  out_pl <= make_res(SlotOutW'(req.slot), STATUS_OK, 1'b0, '0,
                                     err_latch, 1'b1);
                end else begin
                  err_latch <= STATUS_NODEL;
                  out_pl <= make_res(SlotOutW'(req.slot), STATUS_NODEL, 1'b0, '0,
                                     STATUS_NODEL, 1'b1);
                end
              end
              default: begin
                // tick or dispatch: walk the table
                op_dispatch <= (kind_t'(req.kind) == KIND_DISPATCH);
                idx         <= '0;
                n_res       <= '0;
                state       <= S_READ;
              end
            endcase
          end
        end
        S_READ: begin
          if (at_end) begin
            state <= S_FINISH;
          end else if (!slot_valid[cur]) begin
            idx <= idx + 1'b1;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!op_dispatch || (rd_entry.pending == '0)) begin
            idx   <= idx + 1'b1;
            state <= S_READ;
          end else if (disp_go) begin
            // the held result is not the final one, since another follows
            if (hold_valid) begin
              out_valid <= 1'b1;
              out_pl <= make_res(hold_slot, STATUS_OK, 1'b1, hold_task, err_latch, 1'b0);
            end
            hold_valid <= 1'b1;
            hold_slot  <= SlotOutW'(cur);
            hold_task  <= rd_entry.tid;
            n_res      <= n_res + 1'b1;
            if (rd_entry.period == '0) begin
              slot_valid[cur] <= 1'b0;
            end
            idx   <= idx + 1'b1;
            state <= S_READ;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (hold_valid) begin
              out_pl <= make_res(hold_slot, STATUS_OK, 1'b1, hold_task, err_latch, 1'b1);
            end else begin
              out_pl <= make_res(SlotOutW'(NUM_SLOTS), STATUS_OK, 1'b0, '0,
                                 err_latch, 1'b1);
            end
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid        = out_valid;
  assign res.slot_out     = out_pl.slot_out;
  assign res.status       = out_pl.status;
  assign res.ran          = out_pl.ran;
  assign res.run_task_id  = out_pl.run_task_id;
  assign res.sticky_error = out_pl.sticky_error;
  assign res.last         = out_pl.last;

  `ASSERT_SAME(a_res_bound, 1'b1, n_res <= ResCntW'(MaxResults), "too many dispatch results")
  `ASSERT_SAME(a_hold_in_walk, hold_valid, state != S_IDLE, "held result left behind")
  `ASSERT_SAME(a_ram_access, ram_we, (state == S_IDLE) || (state == S_EXEC),
               "table write outside idle or exec")
  `ASSERT_NEXT(a_err_sticky, err_latch != STATUS_OK, err_latch != STATUS_OK,
               "error latch cleared")

endmodule

// ----- tb/sv/sched_scoreboard_pkg.sv -----
// Scoreboard for the scheduler: task-table predictor and in-order result checker.
package sched_scoreboard_pkg;
  import cts_pkg::*;

  localparam int TableSlots = NumSlotsDefault;
  localparam int MaxReports = 40;

  class sched_scoreboard;
    // Own copy of the task table
    bit                  occupied [TableSlots];
    logic [TaskIdW-1:0]  tid      [TableSlots];
    logic [TimeW-1:0]    countdown[TableSlots];
    logic [TimeW-1:0]    reload   [TableSlots];
    logic [PendingW-1:0] runs_due [TableSlots];
    status_t             err_latch;

    res_t due_results[$];
    int   mismatches;
    int   results_seen;
    int   kind_count[4];

    function new();
      for (int i = 0; i < TableSlots; i++) free_slot(i);
      err_latch    = STATUS_OK;
      mismatches   = 0;
      results_seen = 0;
      for (int i = 0; i < 4; i++) kind_count[i] = 0;
    endfunction

    function void free_slot(int i);
      occupied[i]  = 1'b0;
      tid[i]       = '0;
      countdown[i] = '0;
      reload[i]    = '0;
      runs_due[i]  = '0;
    endfunction

    function res_t make_res(int slot_idx, status_t st, logic ran, logic [TaskIdW-1:0] id);
      res_t r;
      r.slot_out     = SlotOutW'(slot_idx);
      r.status       = st;
      r.ran          = ran;
      r.run_task_id  = ran ? id : '0;
      r.sticky_error = err_latch;
      r.last         = 1'b0;
      return r;
    endfunction

    // Apply one accepted request to the table and queue the results it causes.
    function void note_request(kind_t k, logic [TaskIdW-1:0] id, logic [TimeW-1:0] start_dly,
                               logic [TimeW-1:0] period, logic [ReqSlotW-1:0] sl);
      res_t batch[$];
      int   first_free;
      int   s;
      kind_count[int'(k)]++;
      case (k)
        KIND_TICK: begin
          for (int i = 0; i < TableSlots; i++) begin
            if (occupied[i]) begin
              if (countdown[i] == '0) begin
                if (runs_due[i] != '1) runs_due[i] = runs_due[i] + 1'b1;
                if (reload[i] != '0) countdown[i] = reload[i];
              end else begin
                countdown[i] = countdown[i] - 1'b1;
              end
            end
          end
          batch.push_back(make_res(TableSlots, STATUS_OK, 1'b0, '0));
        end
        KIND_ADD: begin
          first_free = -1;
          for (int i = 0; i < TableSlots; i++)
            if (!occupied[i] && first_free < 0) first_free = i;
          if (first_free < 0) begin
            err_latch = STATUS_FULL;
            batch.push_back(make_res(TableSlots, STATUS_FULL, 1'b0, '0));
          end else begin
            occupied[first_free]  = 1'b1;
            tid[first_free]       = id;
            countdown[first_free] = start_dly;
            reload[first_free]    = period;
            runs_due[first_free]  = '0;
            batch.push_back(make_res(first_free, STATUS_OK, 1'b0, '0));
          end
        end
        KIND_DELETE: begin
          s = int'(sl);
          if (!occupied[s]) begin
            free_slot(s);
            err_latch = STATUS_NODEL;
            batch.push_back(make_res(s, STATUS_NODEL, 1'b0, '0));
          end else begin
            free_slot(s);
            batch.push_back(make_res(s, STATUS_OK, 1'b0, '0));
          end
        end
        default: begin
          for (int i = 0; i < TableSlots; i++) begin
            if (occupied[i] && runs_due[i] != '0 && batch.size() < MaxResults) begin
              batch.push_back(make_res(i, STATUS_OK, 1'b1, tid[i]));
              runs_due[i] = runs_due[i] - 1'b1;
              if (reload[i] == '0) free_slot(i);
            end
          end
          if (batch.size() == 0) batch.push_back(make_res(TableSlots, STATUS_OK, 1'b0, '0));
        end
      endcase
      batch[batch.size()-1].last = 1'b1;
      foreach (batch[j]) due_results.push_back(batch[j]);
    endfunction

    function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
    endfunction

    function void check_result(res_t act);
      res_t exp_r;
      results_seen++;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("%0t: unexpected result expected none actual slot %0h status %0h",
                   $time, act.slot_out, act.status);
        return;
      end
      exp_r = due_results.pop_front();
      if (act.slot_out !== exp_r.slot_out)
        report("slot_out", 16'(exp_r.slot_out), 16'(act.slot_out));
      if (act.status !== exp_r.status)
        report("status", 16'(exp_r.status), 16'(act.status));
      if (act.ran !== exp_r.ran)
        report("ran", 16'(exp_r.ran), 16'(act.ran));
      if (act.run_task_id !== exp_r.run_task_id)
        report("run_task_id", 16'(exp_r.run_task_id), 16'(act.run_task_id));
      if (act.sticky_error !== exp_r.sticky_error)
        report("sticky_error", 16'(exp_r.sticky_error), 16'(act.sticky_error));
      if (act.last !== exp_r.last)
        report("last", 16'(exp_r.last), 16'(act.last));
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level testbench of the cooperative task scheduler core.
module tb_top;
  import cts_pkg::*;
  import sched_scoreboard_pkg::*;

  localparam int RandomItems = 156;
  localparam int SatTicks    = 262;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 500000;

  typedef struct {
    kind_t               kind;
    logic [TaskIdW-1:0]  task_id;
    logic [TimeW-1:0]    start_delay;
    logic [TimeW-1:0]    run_period;
    logic [ReqSlotW-1:0] slot;
  } sched_req_t;

  logic clk;
  logic rst;
  bit   steady;
  int   cycles;

  cts_req_if req_ch ();
  cts_res_if res_ch ();

  sched_scoreboard sb;

  cooperative_task_scheduler_core u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  always #6 clk = ~clk;

  // Result side: check accepted results, then stall at random.
  always @(posedge clk) begin
    res_t got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.slot_out     = res_ch.slot_out;
      got.status       = status_t'(res_ch.status);
      got.ran          = res_ch.ran;
      got.run_task_id  = res_ch.run_task_id;
      got.sticky_error = status_t'(res_ch.sticky_error);
      got.last         = res_ch.last;
      sb.check_result(got);
    end
    res_ch.ready <= steady || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.outstanding());
      $display("cooperative_task_scheduler_core: mismatch");
      $finish;
    end
  end

  function automatic sched_req_t mk(kind_t k, logic [TaskIdW-1:0] id, logic [TimeW-1:0] dly,
                                    logic [TimeW-1:0] per, logic [ReqSlotW-1:0] sl);
    sched_req_t r;
    r.kind        = k;
    r.task_id     = id;
    r.start_delay = dly;
    r.run_period  = per;
    r.slot        = sl;
    return r;
  endfunction

  // Mostly short delays and periods so tasks actually fire; a few full-range values.
  function automatic sched_req_t random_request();
    sched_req_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)      r.kind = KIND_TICK;
    else if (pick < 70) r.kind = KIND_ADD;
    else if (pick < 82) r.kind = KIND_DELETE;
    else                r.kind = KIND_DISPATCH;
    r.task_id = TaskIdW'($urandom_range(255));
    r.slot    = ReqSlotW'($urandom_range(7));
    if ($urandom_range(7) == 0) r.start_delay = TimeW'($urandom);
    else                        r.start_delay = TimeW'($urandom_range(6));
    pick = $urandom_range(7);
    if (pick == 0)      r.run_period = TimeW'($urandom);
    else if (pick < 3)  r.run_period = '0;
    else                r.run_period = TimeW'($urandom_range(6, 1));
    return r;
  endfunction

  // Present one request and hold it until the core takes it.
  task automatic send(sched_req_t it);
    if (!steady && $urandom_range(99) < 26) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < 26);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= it.kind;
    req_ch.task_id     <= it.task_id;
    req_ch.start_delay <= it.start_delay;
    req_ch.run_period  <= it.run_period;
    req_ch.slot        <= it.slot;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(it.kind, it.task_id, it.start_delay, it.run_period, it.slot);
  endtask

  initial begin
    sb                 = new();
    clk                = 1'b0;
    rst                = 1'b1;
    steady             = 1'b0;
    cycles             = 0;
    req_ch.valid       = 1'b0;
    req_ch.kind        = KIND_TICK;
    req_ch.task_id     = '0;
    req_ch.start_delay = '0;
    req_ch.run_period  = '0;
    req_ch.slot        = '0;
    res_ch.ready       = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, full table, one-shot removal, delete of an empty slot.
    send(mk(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_DELETE,   8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_TICK,     8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_ADD,      8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_ADD,      8'hFF, 16'hFFFF, 16'hFFFF, 3'd7));
    send(mk(KIND_ADD,      8'hA5, 16'h0001, 16'h0002, 3'd0));
    send(mk(KIND_ADD,      8'h5A, 16'h0000, 16'h0001, 3'd0));
    send(mk(KIND_ADD,      8'h11, 16'h0002, 16'h0003, 3'd0));
    send(mk(KIND_ADD,      8'h22, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_ADD,      8'h44, 16'h0001, 16'h0001, 3'd0));
    send(mk(KIND_ADD,      8'h88, 16'h0000, 16'h0004, 3'd0));
    send(mk(KIND_ADD,      8'h77, 16'h0003, 16'h0003, 3'd0));
    repeat (3) send(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_ADD,      8'h33, 16'h0001, 16'h0000, 3'd0));
    send(mk(KIND_DELETE,   8'h00, 16'h0000, 16'h0000, 3'd7));
    send(mk(KIND_DELETE,   8'h00, 16'h0000, 16'h0000, 3'd7));
    repeat (2) send(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));
    send(mk(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));

    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= 50 && n < 110);
      send(random_request());
    end
    steady = 1'b0;

    // Fill the table, the first three slots with one-shot tasks that fire at once,
    // then tick long enough for the one-shot ones to saturate their pending count.
    for (int s = 0; s < TableSlots; s++)
      send(mk(KIND_DELETE, 8'h00, 16'h0000, 16'h0000, ReqSlotW'(s)));
    for (int s = 0; s < TableSlots; s++)
      send(mk(KIND_ADD, TaskIdW'($urandom_range(255)),
              (s < 3) ? 16'h0000 : TimeW'($urandom_range(3)),
              (s < 3) ? 16'h0000 : TimeW'($urandom_range(3)), 3'd0));
    for (int n = 0; n < SatTicks; n++)
      send(mk(KIND_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0));
    repeat (3) send(mk(KIND_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0));

    req_ch.valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("requests: %0d tick, %0d add, %0d delete, %0d dispatch",
             sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3]);
    $display("results checked: %0d, mismatches: %0d", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("cooperative_task_scheduler_core: match");
    end else begin
      $display("cooperative_task_scheduler_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cts_pkg.sv
rtl/cts_req_if.sv
rtl/cts_res_if.sv
rtl/cts_ram.sv
rtl/cooperative_task_scheduler_core.sv
tb/sv/sched_scoreboard_pkg.sv
tb/sv/tb_top.sv
